// ----- rtl/rws_pkg.sv -----
// shared types, constants and codes for the running and window statistics core
`default_nettype none
package rws_pkg;

  localparam int WIN_DEPTH = 64;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int FW        = AW + 1;
  localparam int NKINDS    = 13;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] CFG_WINDOW_SIZE = 3'd0;
  localparam logic [2:0] CFG_INIT_ZERO   = 3'd1;
  localparam logic [2:0] CFG_BY_COUNT    = 3'd2;
  localparam logic [2:0] CFG_EVERY       = 3'd3;
  localparam logic [2:0] CFG_NO_NEW      = 3'd4;
  localparam logic [2:0] CFG_MASK        = 3'd5;

  localparam logic [3:0] K_LAST = 4'd0;
  localparam logic [3:0] K_AVG  = 4'd1;
  localparam logic [3:0] K_WAVG = 4'd2;
  localparam logic [3:0] K_VAR  = 4'd3;
  localparam logic [3:0] K_WVAR = 4'd4;
  localparam logic [3:0] K_MIN  = 4'd5;
  localparam logic [3:0] K_WMIN = 4'd6;
  localparam logic [3:0] K_MAX  = 4'd7;
  localparam logic [3:0] K_WMAX = 4'd8;
  localparam logic [3:0] K_SUM  = 4'd9;
  localparam logic [3:0] K_WSUM = 4'd10;
  localparam logic [3:0] K_RATE = 4'd11;
  localparam logic [3:0] K_PSUM = 4'd12;

  localparam logic [NKINDS-1:0] ALL_VALID = '1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] sample_value;
    logic [31:0]        now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         stat_kind;
    logic signed [63:0] stat_value;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    U_NOP, U_LATCH, U_CLEAR, U_S_PRE, U_S_WIN, U_MEAN, U_S_DIFF, U_SQ,
    U_DIV_T, U_T, U_T2, U_VAR, U_DIV_MOD, U_R_INIT, U_WAVG, U_W_ADDR,
    U_W_DATA, U_W_ACC, U_R_WVPRE, U_WVAR, U_DIV_RATE, U_RATE, U_R_TIME, U_EMIT
  } uop_t;

  typedef struct packed {
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic go_report;
    logic wavg_ok;
    logic n_ge2;
    logic count_mode;
    logic rem_zero;
    logic walk_done;
    logic fill_gt1;
    logic mask_nz;
    logic rate_ok;
    logic emit_any;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/running_and_window_statistics_core.sv -----
// top level of the running and window statistics core
// a sample runs its update steps with divides on the shared radix-2 divider: one for the
// mean, three more for the variance from the second sample on, one more in count mode; a
// report may divide for the window mean, window variance and rate, reads each window entry
// from the store and emits its results, lowest kind first, while the output is not stalled
// synchronous active-low reset clears all statistics to invalid, no clearing pass
`default_nettype none
module running_and_window_statistics_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rws_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rws_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  import rws_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  rws_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );
endmodule
`default_nettype wire

// ----- rtl/rws_div.sv -----
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle
`default_nettype none
module rws_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quot,
  output logic [31:0]      rem
);
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dsor_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rem_r, quo_r[63]};
  assign trial   = shifted - {1'b0, dsor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 7'd64;
      quo_r  <= dividend;
      rem_r  <= '0;
      dsor_r <= divisor;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
      cnt_r  <= cnt_r - 7'd1;
      done_r <= (cnt_r == 7'd1);
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ----- rtl/rws_datapath.sv -----
// statistics registers, window store, divider, multiplier and result register
`default_nettype none
module rws_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rws_pkg::dp_cmd_t  cmd,
  input  wire rws_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output rws_pkg::out_item_t     out_data,
  output rws_pkg::dp_status_t    status
);
  import rws_pkg::*;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic [FW-1:0] win_clamp(logic [6:0] s);
    if (s == 7'd0) begin
      return FW'(1);
    end else if ({25'b0, s} > 32'(WIN_DEPTH)) begin
      return FW'(WIN_DEPTH);
    end else begin
      return FW'(s);
    end
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) begin
      return S64_MAX;
    end else if (a[63] && b[63] && !s[63]) begin
      return S64_MIN;
    end
    return s;
  endfunction

  function automatic logic [32:0] abs33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] clamp63(logic [63:0] v);
    return v[63] ? 64'h7FFF_FFFF_FFFF_FFFF : v;
  endfunction

  // configuration
  logic [6:0]        cfg_wsize_r;
  logic              cfg_izero_r;
  logic              cfg_bycount_r;
  logic [15:0]       cfg_every_r;
  logic              cfg_rwn_r;
  logic [NKINDS-1:0] cfg_mask_r;

  // statistics state
  logic signed [31:0] smp_r;
  logic [31:0]        now_r;
  logic [31:0]        count_r;
  logic [NKINDS-1:0]  valid_r;
  logic signed [31:0] last_r;
  logic signed [63:0] total_r;
  logic signed [63:0] psum_r;
  logic signed [63:0] racc_r;
  logic signed [31:0] mean_r;
  logic [63:0]        var_r;
  logic signed [31:0] min_r;
  logic signed [31:0] max_r;
  logic signed [63:0] wsum_r;
  logic [FW-1:0]      fill_r;
  logic [AW-1:0]      pos_r;
  logic [FW-1:0]      active_r;
  logic signed [63:0] rate_r;
  logic [31:0]        ltime_r;
  logic               have_r;
  logic               newd_r;

  // report and work registers
  logic signed [31:0] wavg_r;
  logic signed [31:0] wmin_r;
  logic signed [31:0] wmax_r;
  logic [63:0]        acc_r;
  logic [63:0]        wsq_r;
  logic [63:0]        t_r;
  logic [31:0]        mag_r;
  logic [63:0]        prod_r;
  logic [FW-1:0]      idx_r;
  logic               neg_r;
  logic [NKINDS-1:0]  emit_r;
  out_item_t          out_r;
  logic               out_valid_r;

  // window store
  logic signed [31:0] mem [WIN_DEPTH];
  logic signed [31:0] rdata_r;
  logic [AW-1:0]      raddr;
  logic               mem_we;

  // divider
  logic        div_start;
  logic [63:0] div_dend;
  logic [31:0] div_dsor;
  logic        div_done;
  logic [63:0] div_quot;
  logic [31:0] div_rem;
  logic [63:0] q_s;

  logic signed [32:0] d_mean;
  logic signed [32:0] d_win;
  logic [32:0]        d_mean_abs;
  logic [32:0]        d_win_abs;
  logic [31:0]        m1;
  logic [31:0]        dt;
  logic [15:0]        every;
  logic               wavg_ok;
  logic               fill_gt1;
  logic               out_free;
  logic [FW-1:0]      pos_p1;
  logic signed [63:0] smp64;
  logic signed [63:0] wtmp;
  logic [63:0]        vsub;
  logic [64:0]        vsum;
  logic [3:0]         sel_kind;
  logic signed [63:0] sel_val;
  logic [NKINDS-1:0]  emit_rest;

  rws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (div_dsor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign smp64    = {{32{smp_r[31]}}, smp_r};
  assign d_mean   = {smp_r[31], smp_r} - {mean_r[31], mean_r};
  assign d_win    = {wavg_r[31], wavg_r} - {rdata_r[31], rdata_r};
  assign d_mean_abs = abs33(d_mean);
  assign d_win_abs  = abs33(d_win);
  assign m1       = count_r - 32'd1;
  assign dt       = now_r - ltime_r;
  assign every    = (cfg_every_r == 16'd0) ? 16'd1 : cfg_every_r;
  assign wavg_ok  = (fill_r != '0) && valid_r[K_WSUM];
  assign fill_gt1 = fill_r > FW'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign pos_p1   = {1'b0, pos_r} + FW'(1);
  assign q_s      = neg_r ? (64'd0 - div_quot) : div_quot;
  assign wtmp     = (fill_r < active_r) ? wsum_r : wsum_r - {{32{rdata_r[31]}}, rdata_r};
  assign vsub     = var_r - div_quot;
  assign vsum     = {1'b0, vsub} + {1'b0, t_r};
  assign emit_rest = emit_r & (emit_r - NKINDS'(1));

  always_comb begin
    div_start = 1'b0;
    div_dend  = '0;
    div_dsor  = 32'd1;
    case (cmd.uop)
      U_S_WIN: begin
        div_start = 1'b1;
        div_dend  = {31'b0, d_mean_abs};
        div_dsor  = count_r;
      end
      U_DIV_T: begin
        div_start = 1'b1;
        div_dend  = {16'b0, prod_r[63:16]};
        div_dsor  = m1;
      end
      U_T: begin
        div_start = 1'b1;
        div_dend  = div_quot;
        div_dsor  = m1;
      end
      U_T2: begin
        div_start = 1'b1;
        div_dend  = var_r;
        div_dsor  = m1;
      end
      U_DIV_MOD: begin
        div_start = 1'b1;
        div_dend  = {32'b0, count_r};
        div_dsor  = {16'b0, every};
      end
      U_R_INIT: begin
        div_start = wavg_ok;
        div_dend  = abs64(wsum_r);
        div_dsor  = 32'(fill_r);
      end
      U_R_WVPRE: begin
        div_start = fill_gt1;
        div_dend  = acc_r;
        div_dsor  = 32'(fill_r - FW'(1));
      end
      U_DIV_RATE: begin
        div_start = 1'b1;
        div_dend  = abs64(racc_r);
        div_dsor  = dt;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign mem_we = (cmd.uop == U_S_WIN);
  assign raddr  = (cmd.uop == U_W_ADDR) ? idx_r[AW-1:0] : pos_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= smp_r;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_wsize_r   <= 7'd64;
      cfg_izero_r   <= 1'b0;
      cfg_bycount_r <= 1'b0;
      cfg_every_r   <= 16'd1;
      cfg_rwn_r     <= 1'b0;
      cfg_mask_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: cfg_wsize_r   <= cfg_wdata[6:0];
        CFG_INIT_ZERO:   cfg_izero_r   <= cfg_wdata[0];
        CFG_BY_COUNT:    cfg_bycount_r <= cfg_wdata[0];
        CFG_EVERY:       cfg_every_r   <= cfg_wdata;
        CFG_NO_NEW:      cfg_rwn_r     <= cfg_wdata[0];
        CFG_MASK:        cfg_mask_r    <= cfg_wdata[NKINDS-1:0];
        default:         cfg_mask_r    <= cfg_mask_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      valid_r  <= '0;
      last_r   <= '0;
      total_r  <= '0;
      psum_r   <= '0;
      racc_r   <= '0;
      mean_r   <= '0;
      var_r    <= '0;
      min_r    <= '0;
      max_r    <= '0;
      wsum_r   <= '0;
      fill_r   <= '0;
      pos_r    <= '0;
      active_r <= win_clamp(7'd64);
      rate_r   <= '0;
      ltime_r  <= '0;
      have_r   <= 1'b0;
      newd_r   <= 1'b0;
      emit_r   <= '0;
      idx_r    <= '0;
      neg_r    <= 1'b0;
    end else begin
      case (cmd.uop)
        U_LATCH: begin
          smp_r <= in_data.sample_value;
          now_r <= in_data.now_ticks;
        end
        U_CLEAR: begin
          count_r  <= '0;
          valid_r  <= cfg_izero_r ? ALL_VALID : '0;
          last_r   <= '0;
          total_r  <= '0;
          psum_r   <= '0;
          racc_r   <= '0;
          mean_r   <= '0;
          var_r    <= '0;
          min_r    <= '0;
          max_r    <= '0;
          wsum_r   <= '0;
          fill_r   <= '0;
          pos_r    <= '0;
          active_r <= win_clamp(cfg_wsize_r);
          rate_r   <= '0;
        end
        U_S_PRE: begin
          count_r <= (count_r == 32'hFFFF_FFFF) ? count_r : count_r + 32'd1;
          last_r  <= smp_r;
          total_r <= valid_r[K_SUM] ? sat_add(total_r, smp64) : smp64;
          psum_r  <= valid_r[K_PSUM] ? sat_add(psum_r, smp64) : smp64;
          racc_r  <= sat_add(racc_r, smp64);
          mean_r  <= valid_r[K_AVG] ? mean_r : '0;
          var_r   <= valid_r[K_VAR] ? var_r : '0;
          if (!valid_r[K_MIN] || smp_r < min_r) begin
            min_r <= smp_r;
          end
          if (!valid_r[K_MAX] || smp_r > max_r) begin
            max_r <= smp_r;
          end
          valid_r[K_LAST] <= 1'b1;
          valid_r[K_SUM]  <= 1'b1;
          valid_r[K_PSUM] <= 1'b1;
          valid_r[K_AVG]  <= 1'b1;
          valid_r[K_MIN]  <= 1'b1;
          valid_r[K_MAX]  <= 1'b1;
        end
        U_S_WIN: begin
          if (fill_r < active_r) begin
            fill_r <= fill_r + FW'(1);
          end
          wsum_r <= valid_r[K_WSUM] ? wtmp + smp64 : smp64;
          valid_r[K_WSUM] <= 1'b1;
          pos_r  <= (pos_p1 >= active_r) ? '0 : pos_p1[AW-1:0];
          newd_r <= 1'b1;
          neg_r  <= d_mean[32];
        end
        U_MEAN: begin
          mean_r <= mean_r + q_s[31:0];
          if (count_r < 32'd2) begin
            var_r <= '0;
          end
          valid_r[K_VAR] <= 1'b1;
        end
        U_S_DIFF: begin
          mag_r <= d_mean_abs[31:0];
        end
        U_SQ: begin
          prod_r <= mag_r * mag_r;
        end
        U_T: begin
          t_r <= div_quot;
        end
        U_T2: begin
          t_r <= t_r + div_quot;
        end
        U_VAR: begin
          var_r <= clamp63(vsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : vsum[63:0]);
        end
        U_R_INIT: begin
          newd_r <= 1'b0;
          wmin_r <= last_r;
          wmax_r <= last_r;
          valid_r[K_WMIN] <= valid_r[K_LAST];
          valid_r[K_WMAX] <= valid_r[K_LAST];
          acc_r <= '0;
          idx_r <= '0;
          neg_r <= wsum_r[63];
          if (!wavg_ok) begin
            wavg_r <= '0;
            valid_r[K_WAVG] <= 1'b0;
          end
        end
        U_WAVG: begin
          wavg_r <= q_s[31:0];
          valid_r[K_WAVG] <= 1'b1;
        end
        U_W_DATA: begin
          if (rdata_r < wmin_r) begin
            wmin_r <= rdata_r;
          end
          if (rdata_r > wmax_r) begin
            wmax_r <= rdata_r;
          end
          mag_r <= d_win_abs[31:0];
        end
        U_W_ACC: begin
          acc_r <= acc_r + {16'b0, prod_r[63:16]};
          idx_r <= idx_r + FW'(1);
        end
        U_R_WVPRE: begin
          valid_r[K_WVAR] <= fill_gt1 && valid_r[K_WAVG];
          if (!fill_gt1) begin
            wsq_r <= clamp63(acc_r);
          end
        end
        U_WVAR: begin
          wsq_r <= clamp63(div_quot);
        end
        U_DIV_RATE: begin
          neg_r <= racc_r[63];
        end
        U_RATE: begin
          rate_r <= q_s;
          valid_r[K_RATE] <= 1'b1;
        end
        U_R_TIME: begin
          have_r  <= 1'b1;
          ltime_r <= now_r;
          racc_r  <= '0;
          emit_r  <= cfg_mask_r & valid_r;
          valid_r[K_PSUM] <= 1'b0;
        end
        U_EMIT: begin
          if (emit_r != '0 && out_free) begin
            emit_r <= emit_rest;
          end
        end
        default: begin
          neg_r <= neg_r;
        end
      endcase
    end
  end

  // result selection, lowest pending kind first
  always_comb begin
    sel_kind = K_LAST;
    for (int k = NKINDS - 1; k >= 0; k--) begin
      if (emit_r[k]) begin
        sel_kind = 4'(k);
      end
    end
  end

  always_comb begin
    case (sel_kind)
      K_LAST:  sel_val = {{32{last_r[31]}}, last_r};
      K_AVG:   sel_val = {{32{mean_r[31]}}, mean_r};
      K_WAVG:  sel_val = {{32{wavg_r[31]}}, wavg_r};
      K_VAR:   sel_val = var_r;
      K_WVAR:  sel_val = wsq_r;
      K_MIN:   sel_val = {{32{min_r[31]}}, min_r};
      K_WMIN:  sel_val = {{32{wmin_r[31]}}, wmin_r};
      K_MAX:   sel_val = {{32{max_r[31]}}, max_r};
      K_WMAX:  sel_val = {{32{wmax_r[31]}}, wmax_r};
      K_SUM:   sel_val = total_r;
      K_WSUM:  sel_val = wsum_r;
      K_RATE:  sel_val = rate_r;
      K_PSUM:  sel_val = psum_r;
      default: sel_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.uop == U_EMIT && emit_r != '0 && out_free) begin
      out_valid_r       <= 1'b1;
      out_r.stat_kind   <= sel_kind;
      out_r.stat_value  <= sel_val;
      out_r.last_of_run <= (emit_rest == '0);
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign status.div_done   = div_done;
  assign status.go_report  = newd_r || cfg_rwn_r;
  assign status.wavg_ok    = wavg_ok;
  assign status.n_ge2      = count_r > 32'd1;
  assign status.count_mode = cfg_bycount_r;
  assign status.rem_zero   = (div_rem == 32'd0);
  assign status.walk_done  = (idx_r == fill_r);
  assign status.fill_gt1   = fill_gt1;
  assign status.mask_nz    = (cfg_mask_r != '0);
  assign status.rate_ok    = have_r && (dt != 32'd0);
  assign status.emit_any   = (emit_r != '0);
  assign status.emit_last  = (emit_rest == '0);
  assign status.out_free   = out_free;
endmodule
`default_nettype wire

// ----- rtl/rws_ctrl.sv -----
// sequencing state machine for samples, reports and clears
`default_nettype none
module rws_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_opcode,
  input  wire rws_pkg::dp_status_t status,
  output logic                     in_stall,
  output rws_pkg::dp_cmd_t         cmd
);
  import rws_pkg::*;

  typedef enum logic [33:0] {
    ST_IDLE   = 34'd1 << 0,
    ST_S_PRE  = 34'd1 << 1,
    ST_S_WIN  = 34'd1 << 2,
    ST_S_WM   = 34'd1 << 3,
    ST_S_MEAN = 34'd1 << 4,
    ST_S_DIFF = 34'd1 << 5,
    ST_S_SQ   = 34'd1 << 6,
    ST_S_DT   = 34'd1 << 7,
    ST_S_WT   = 34'd1 << 8,
    ST_S_T    = 34'd1 << 9,
    ST_S_WT2  = 34'd1 << 10,
    ST_S_T2   = 34'd1 << 11,
    ST_S_WV   = 34'd1 << 12,
    ST_S_VAR  = 34'd1 << 13,
    ST_S_CNT  = 34'd1 << 14,
    ST_S_WMOD = 34'd1 << 15,
    ST_R_CHK  = 34'd1 << 16,
    ST_R_INIT = 34'd1 << 17,
    ST_R_WA   = 34'd1 << 18,
    ST_R_WAVG = 34'd1 << 19,
    ST_W_CHK  = 34'd1 << 20,
    ST_W_ADDR = 34'd1 << 21,
    ST_W_DATA = 34'd1 << 22,
    ST_W_SQ   = 34'd1 << 23,
    ST_W_ACC  = 34'd1 << 24,
    ST_R_WV   = 34'd1 << 25,
    ST_R_WWV  = 34'd1 << 26,
    ST_R_WVAR = 34'd1 << 27,
    ST_R_MASK = 34'd1 << 28,
    ST_R_WR   = 34'd1 << 29,
    ST_R_RATE = 34'd1 << 30,
    ST_R_TIME = 34'd1 << 31,
    ST_EMIT   = 34'd1 << 32,
    ST_CLR    = 34'd1 << 33
  } state_t;

  state_t state_r;
  state_t state_nxt;
  uop_t   uop;

  always_comb begin
    state_nxt = state_r;
    uop       = U_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          uop = U_LATCH;
          case (in_opcode)
            OP_SAMPLE: state_nxt = ST_S_PRE;
            OP_REPORT: state_nxt = ST_R_CHK;
            OP_CLEAR:  state_nxt = ST_CLR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_S_PRE: begin
        uop = U_S_PRE;
        state_nxt = ST_S_WIN;
      end
      ST_S_WIN: begin
        uop = U_S_WIN;
        state_nxt = ST_S_WM;
      end
      ST_S_WM: begin
        if (status.div_done) state_nxt = ST_S_MEAN;
      end
      ST_S_MEAN: begin
        uop = U_MEAN;
        state_nxt = status.n_ge2 ? ST_S_DIFF : ST_S_CNT;
      end
      ST_S_DIFF: begin
        uop = U_S_DIFF;
        state_nxt = ST_S_SQ;
      end
      ST_S_SQ: begin
        uop = U_SQ;
        state_nxt = ST_S_DT;
      end
      ST_S_DT: begin
        uop = U_DIV_T;
        state_nxt = ST_S_WT;
      end
      ST_S_WT: begin
        if (status.div_done) state_nxt = ST_S_T;
      end
      ST_S_T: begin
        uop = U_T;
        state_nxt = ST_S_WT2;
      end
      ST_S_WT2: begin
        if (status.div_done) state_nxt = ST_S_T2;
      end
      ST_S_T2: begin
        uop = U_T2;
        state_nxt = ST_S_WV;
      end
      ST_S_WV: begin
        if (status.div_done) state_nxt = ST_S_VAR;
      end
      ST_S_VAR: begin
        uop = U_VAR;
        state_nxt = ST_S_CNT;
      end
      ST_S_CNT: begin
        uop = status.count_mode ? U_DIV_MOD : U_NOP;
        state_nxt = status.count_mode ? ST_S_WMOD : ST_IDLE;
      end
      ST_S_WMOD: begin
        if (status.div_done) state_nxt = status.rem_zero ? ST_R_CHK : ST_IDLE;
      end
      ST_R_CHK: begin
        state_nxt = status.go_report ? ST_R_INIT : ST_IDLE;
      end
      ST_R_INIT: begin
        uop = U_R_INIT;
        state_nxt = status.wavg_ok ? ST_R_WA : ST_W_CHK;
      end
      ST_R_WA: begin
        if (status.div_done) state_nxt = ST_R_WAVG;
      end
      ST_R_WAVG: begin
        uop = U_WAVG;
        state_nxt = ST_W_CHK;
      end
      ST_W_CHK: begin
        state_nxt = status.walk_done ? ST_R_WV : ST_W_ADDR;
      end
      ST_W_ADDR: begin
        uop = U_W_ADDR;
        state_nxt = ST_W_DATA;
      end
      ST_W_DATA: begin
        uop = U_W_DATA;
        state_nxt = ST_W_SQ;
      end
      ST_W_SQ: begin
        uop = U_SQ;
        state_nxt = ST_W_ACC;
      end
      ST_W_ACC: begin
        uop = U_W_ACC;
        state_nxt = ST_W_CHK;
      end
      ST_R_WV: begin
        uop = U_R_WVPRE;
        state_nxt = status.fill_gt1 ? ST_R_WWV : ST_R_MASK;
      end
      ST_R_WWV: begin
        if (status.div_done) state_nxt = ST_R_WVAR;
      end
      ST_R_WVAR: begin
        uop = U_WVAR;
        state_nxt = ST_R_MASK;
      end
      ST_R_MASK: begin
        uop = (status.mask_nz && status.rate_ok) ? U_DIV_RATE : U_NOP;
        if (!status.mask_nz) begin
          state_nxt = ST_IDLE;
        end else if (status.rate_ok) begin
          state_nxt = ST_R_WR;
        end else begin
          state_nxt = ST_R_TIME;
        end
      end
      ST_R_WR: begin
        if (status.div_done) state_nxt = ST_R_RATE;
      end
      ST_R_RATE: begin
        uop = U_RATE;
        state_nxt = ST_R_TIME;
      end
      ST_R_TIME: begin
        uop = U_R_TIME;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        uop = U_EMIT;
        if (!status.emit_any) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free && status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        uop = U_CLEAR;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign cmd.uop  = uop;
endmodule
`default_nettype wire

// ----- tb/tb_running_and_window_statistics_core.sv -----
// testbench for the running and window statistics core: queue-fed driver, predictor, monitor
`timescale 1ns / 100ps
module tb_running_and_window_statistics_core;
  import rws_pkg::*;

  localparam longint SMAX = 64'sh7fffffffffffffff;
  localparam longint SMIN = -64'sh7fffffffffffffff - 1;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 1200;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = CFG_WINDOW_SIZE;
  logic [15:0] cfg_wdata = '0;

  running_and_window_statistics_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  in_item_t pending_items[$];
  out_item_t expected_stats[$];
  int errors = 0;
  int snd_idle = 0, rcv_idle = 0;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int n_items = 0, n_stats = 0, n_reports = 0;
  int unsigned cycles = 0;
  logic [31:0] ticks = 0;

  // configuration copy
  int unsigned c_wsize, c_iz, c_bc, c_every, c_nonew, c_mask;
  // statistics state copy
  logic [31:0] cnt;
  logic [12:0] vld;
  longint last_s, tsum, psum, racc, rmean, rvar, mn, mx, wsum, rate;
  int unsigned fill, pos, asize;
  longint wstore[64];
  logic [31:0] lrt;
  bit have_t, newf;

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > SMAX - b) return SMAX;
    if (b < 0 && a < SMIN - b) return SMIN;
    return a + b;
  endfunction

  function automatic longint unsigned sq_q16(longint d);
    longint unsigned u;
    u = d;
    if (d < 0) u = -u;
    return (u * u) >> 16;
  endfunction

  task automatic clear_stats();
    int unsigned s;
    s = c_wsize;
    if (s < 1) s = 1;
    if (s > 64) s = 64;
    asize = s;
    cnt = 0;
    last_s = 0; tsum = 0; psum = 0; racc = 0; rmean = 0; rvar = 0;
    mn = 0; mx = 0; wsum = 0; rate = 0; fill = 0; pos = 0;
    vld = c_iz ? ALL_VALID : '0;
  endtask

  task automatic set_config(logic [2:0] idx, int unsigned v);
    case (idx)
      CFG_WINDOW_SIZE: c_wsize = v & 'h7f;
      CFG_INIT_ZERO:   c_iz = v & 1;
      CFG_BY_COUNT:    c_bc = v & 1;
      CFG_EVERY:       c_every = v & 'hffff;
      CFG_NO_NEW:      c_nonew = v & 1;
      CFG_MASK:        c_mask = v & 'h1fff;
      default: ;
    endcase
  endtask

  task automatic predict_report(logic [31:0] now);
    longint wavg, wmin, wmax, x;
    longint unsigned wsq;
    longint vals[13];
    out_item_t run[$];
    out_item_t o;
    int unsigned j;
    logic [31:0] dt;
    wavg = 0;
    wsq = 0;
    if (!newf && c_nonew == 0) return;
    newf = 0;
    wmin = last_s;
    wmax = last_s;
    vld[K_WMIN] = vld[K_LAST];
    vld[K_WMAX] = vld[K_LAST];
    if (fill > 0 && vld[K_WSUM]) begin
      wavg = wsum / longint'(fill);
      vld[K_WAVG] = 1;
    end else begin
      vld[K_WAVG] = 0;
    end
    for (int unsigned i = 1; i <= fill && i <= asize; i++) begin
      j = pos + asize - i;
      if (j >= asize) j -= asize;
      x = wstore[j % 64];
      if (x < wmin) wmin = x;
      if (x > wmax) wmax = x;
      wsq += sq_q16(wavg - x);
    end
    vld[K_WVAR] = fill > 1 && vld[K_WAVG];
    if (fill > 1) wsq = wsq / longint'(fill - 1);
    if (wsq > longint'(SMAX)) wsq = SMAX;
    if (c_mask == 0) return;
    if (have_t) begin
      dt = now - lrt;
      if (dt != 0) begin
        rate = racc / longint'({32'd0, dt});
        vld[K_RATE] = 1;
      end
    end
    have_t = 1;
    lrt = now;
    racc = 0;
    vals[K_LAST] = last_s; vals[K_AVG] = rmean; vals[K_WAVG] = wavg;
    vals[K_VAR] = rvar;    vals[K_WVAR] = wsq;  vals[K_MIN] = mn;
    vals[K_WMIN] = wmin;   vals[K_MAX] = mx;    vals[K_WMAX] = wmax;
    vals[K_SUM] = tsum;    vals[K_WSUM] = wsum; vals[K_RATE] = rate;
    vals[K_PSUM] = psum;
    for (int k = 0; k < NKINDS; k++) begin
      if (c_mask[k] && vld[k]) begin
        o.stat_kind = 4'(k);
        o.stat_value = vals[k];
        o.last_of_run = 0;
        run.push_back(o);
      end
    end
    if (run.size() > 0) begin
      run[run.size() - 1].last_of_run = 1;
      n_reports++;
    end
    foreach (run[i]) expected_stats.push_back(run[i]);
    vld[K_PSUM] = 0;
  endtask

  task automatic predict_sample(longint r, logic [31:0] now);
    longint unsigned n, m1, v, t, every;
    if (cnt != '1) cnt++;
    n = cnt;
    last_s = r;
    vld[K_LAST] = 1;
    tsum = vld[K_SUM] ? sat_sum(tsum, r) : r;
    vld[K_SUM] = 1;
    psum = vld[K_PSUM] ? sat_sum(psum, r) : r;
    vld[K_PSUM] = 1;
    racc = sat_sum(racc, r);
    if (!vld[K_AVG]) rmean = 0;
    rmean += (r - rmean) / longint'(n);
    vld[K_AVG] = 1;
    if (n < 2) begin
      rvar = 0;
    end else begin
      m1 = n - 1;
      v = vld[K_VAR] ? rvar : 0;
      t = sq_q16(r - rmean) / m1;
      v = v - v / m1;
      t = t + t / m1;
      v = (v > longint'(SMAX) - t) ? SMAX : v + t;
      rvar = v;
    end
    vld[K_VAR] = 1;
    if (!vld[K_MIN] || r < mn) mn = r;
    vld[K_MIN] = 1;
    if (!vld[K_MAX] || r > mx) mx = r;
    vld[K_MAX] = 1;
    if (fill < asize) fill++;
    else wsum -= wstore[pos % 64];
    wsum = vld[K_WSUM] ? wsum + r : r;
    vld[K_WSUM] = 1;
    wstore[pos % 64] = r;
    pos++;
    if (pos >= asize) pos = 0;
    newf = 1;
    every = c_every ? c_every : 1;
    if (c_bc && (n % every) == 0) predict_report(now);
  endtask

  task automatic predict_item(in_item_t it);
    case (it.opcode)
      OP_SAMPLE: predict_sample(longint'(it.sample_value), it.now_ticks);
      OP_REPORT: predict_report(it.now_ticks);
      OP_CLEAR:  clear_stats();
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          predict_item(in_data);
          n_items++;
        end
        if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 3000;
      out_stall <= 1;
    end else begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1) || ($urandom_range(99) < rcv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual kind %0d value %0d last %0b",
                 $time, out_data.stat_kind, out_data.stat_value, out_data.last_of_run);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        n_stats++;
        if (out_data.stat_kind !== e.stat_kind) begin
          $display("%0t stat_kind: expected %0d actual %0d", $time, e.stat_kind,
                   out_data.stat_kind);
          errors++;
        end
        if (out_data.stat_value !== e.stat_value) begin
          $display("%0t stat_value (kind %0d): expected %0d actual %0d", $time,
                   e.stat_kind, e.stat_value, out_data.stat_value);
          errors++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $display("%0t last_of_run: expected %0b actual %0b", $time, e.last_of_run,
                   out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    set_config(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic push(logic [1:0] op, logic [31:0] v, logic [31:0] t);
    in_item_t it;
    it.opcode = op;
    it.sample_value = v;
    it.now_ticks = t;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_stats.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(32'h00140000) - 32'h000a0000;
    endcase
  endfunction

  task automatic rand_items(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      case ($urandom_range(9))
        0: ticks = $urandom;
        1: ;
        default: ticks = ticks + $urandom_range(2000);
      endcase
      if (sel < 62) push(OP_SAMPLE, rand_value(), ticks);
      else if (sel < 88) push(OP_REPORT, $urandom, ticks);
      else if (sel < 95) push(OP_CLEAR, $urandom, ticks);
      else push(2'd3, $urandom, ticks);
    end
  endtask

  task automatic rand_config();
    case ($urandom_range(5))
      0: cfg_write(CFG_WINDOW_SIZE, 1);
      1: cfg_write(CFG_WINDOW_SIZE, 64);
      2: cfg_write(CFG_WINDOW_SIZE, $urandom_range(127));
      default: cfg_write(CFG_WINDOW_SIZE, $urandom_range(2, 12));
    endcase
    cfg_write(CFG_INIT_ZERO, $urandom_range(1));
    cfg_write(CFG_BY_COUNT, $urandom_range(3) == 0);
    cfg_write(CFG_EVERY, $urandom_range(4) == 0 ? $urandom : $urandom_range(6));
    cfg_write(CFG_NO_NEW, $urandom_range(1));
    case ($urandom_range(4))
      0: cfg_write(CFG_MASK, ALL_VALID);
      1: cfg_write(CFG_MASK, 0);
      default: cfg_write(CFG_MASK, $urandom);
    endcase
    push(OP_CLEAR, 0, ticks);
  endtask

  initial begin
    c_wsize = 64; c_iz = 0; c_bc = 0; c_every = 1; c_nonew = 0; c_mask = 0;
    foreach (wstore[i]) wstore[i] = 0;
    lrt = 0; have_t = 0; newf = 0;
    clear_stats();
    vld = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed part
    snd_idle = 18; rcv_idle = 59;
    cfg_write(CFG_MASK, ALL_VALID);
    push(OP_REPORT, 0, 50);
    push(OP_SAMPLE, 32'h7fffffff, 100);
    push(OP_SAMPLE, 32'h80000000, 100);
    push(OP_REPORT, 0, 200);
    push(OP_REPORT, 0, 200);
    push(OP_SAMPLE, 32'h00018000, 250);
    push(OP_REPORT, 0, 200);
    push(2'd3, 32'hffffffff, 32'hffffffff);
    push(OP_CLEAR, 0, 0);
    drain();
    cfg_write(CFG_NO_NEW, 1);
    push(OP_REPORT, 0, 300);
    push(OP_REPORT, 0, 300);
    drain();
    cfg_write(CFG_INIT_ZERO, 1);
    cfg_write(CFG_WINDOW_SIZE, 1);
    push(OP_CLEAR, 0, 0);
    push(OP_REPORT, 0, 400);
    push(OP_SAMPLE, 32'hfffe0000, 500);
    push(OP_REPORT, 0, 32'h00000010);
    drain();
    cfg_write(CFG_MASK, 0);
    cfg_write(CFG_WINDOW_SIZE, 0);
    push(OP_CLEAR, 0, 0);
    push(OP_SAMPLE, 32'h00010000, 600);
    push(OP_REPORT, 0, 700);
    drain();
    cfg_write(CFG_MASK, ALL_VALID);
    cfg_write(CFG_WINDOW_SIZE, 127);
    cfg_write(CFG_BY_COUNT, 1);
    cfg_write(CFG_EVERY, 0);
    push(OP_CLEAR, 0, 0);
    push(OP_SAMPLE, 32'h00020000, 800);
    push(OP_SAMPLE, 32'hffff0000, 900);
    drain();
    cfg_write(CFG_EVERY, 16'hffff);
    push(OP_SAMPLE, 32'h00030000, 1000);
    drain();

    // random part in three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 18 : (ph == 1) ? 59 : 0;
      rcv_idle = (ph == 0) ? 59 : (ph == 1) ? 18 : 0;
      for (int b = 0; b < 4; b++) begin
        rand_config();
        if (ph == 2 && b == 0) begin
          drain();
          cfg_write(CFG_BY_COUNT, 1);
          cfg_write(CFG_EVERY, 1);
          cfg_write(CFG_MASK, ALL_VALID);
          for (int i = 0; i < 12; i++) push(OP_SAMPLE, rand_value(), ticks + i);
          hold_reqs++;
        end
        rand_items(42);
        drain();
      end
    end

    $display("covered %0d accepted items, %0d checked results in %0d report runs",
             n_items, n_stats, n_reports);
    $display("three idling regimes, one long receiver hold-off, varied window and mask");
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
